### rtl/sme_pkg.sv
// ============================================================================
// sme_pkg
// Shared types and constants for the stack machine executor: opcode and
// status codes, controller states and channel widths.
// ============================================================================
package sme_pkg;

   // Default number of stack entries
   localparam int STACK_DEPTH_DEF = 256;

   // Data word and channel widths
   localparam int WORD_W      = 32;
   localparam int OP_W        = 3;
   localparam int STATUS_W    = 3;
   localparam int DEPTH_OUT_W = 9;
   localparam int REQ_DATA_W  = 32;
   localparam int REQ_USER_W  = 3;
   localparam int RSP_DATA_W  = 48;
   localparam int RSP_USER_W  = 4;
   localparam int RSP_PAD_W   = RSP_DATA_W - WORD_W - DEPTH_OUT_W - 1;

   // Divider step counter
   localparam int STEP_W = $clog2(WORD_W);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH    = 3'd0,
      OP_ADD     = 3'd1,
      OP_SUB     = 3'd2,
      OP_MUL     = 3'd3,
      OP_DIV     = 3'd4,
      OP_PRINT   = 3'd5,
      OP_HALT    = 3'd6,
      OP_UNKNOWN = 3'd7
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_UNKNOWN   = 3'd1,
      ST_OVERFLOW  = 3'd2,
      ST_UNDERFLOW = 3'd3,
      ST_DIVZERO   = 3'd4,
      ST_HALTED    = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_FETCH,
      S_CALC,
      S_DIV,
      S_SIGN,
      S_WRITE,
      S_DONE
   } state_type;

endpackage

### rtl/stack_machine_executor.sv
// ============================================================================
// stack_machine_executor
// Executes one stack-machine instruction per request word on a stack of
// signed 32-bit words held in a RAM, and returns one status word per request.
// ============================================================================
//
// Channel | Direction | tdata                             | tuser
// --------+-----------+-----------------------------------+----------------------
// req_    | in        | [31:0] operand                    | [2:0] opcode
// rsp_    | out       | [31:0] print_value, [40:32] depth,| [2:0] status,
//         |           | [41] halted, [47:42] zero         | [3] print_valid
//
// Push, print, halt and every error case go from decode straight to done;
// add, sub and mul pass through fetch, calc and write; div passes through
// fetch, the 32 one-bit steps of the restoring divider, sign and write.
// The next word is accepted at the edge of the earliest result handshake.
// The top of stack lives in a register, so an instruction reads the RAM at
// most once (the second entry) and writes it at most once.
// Reset clears the depth, halted flag, output valid and controller; the RAM
// is not cleared, since only entries below the depth are ever read.
// A result waits in the output register while the next word is accepted; the
// controller stalls in its last state only if a new result is ready first.
// ============================================================================
module stack_machine_executor #(
   parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sme_pkg::REQ_DATA_W-1:0]  req_tdata,  // [31:0] operand
   input  logic [sme_pkg::REQ_USER_W-1:0]  req_tuser,  // [2:0] opcode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [31:0] print_value, [40:32] stack_depth, [41] halted, [47:42] zero
   output logic [sme_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [2:0] status, [3] print_valid
   output logic [sme_pkg::RSP_USER_W-1:0]  rsp_tuser
);

   import sme_pkg::*;

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

   state_type               state_ff, state_in;
   opcode_type              op_ff, op_in;
   logic [WORD_W-1:0]       operand_ff, operand_in;
   logic [CNT_W-1:0]        depth_ff, depth_in;
   logic                    stopped_ff, stopped_in;
   logic [WORD_W-1:0]       top_ff, top_in;
   logic [WORD_W-1:0]       second_ff, second_in;
   logic [WORD_W-1:0]       res_ff, res_in;
   status_type              status_ff, status_in;
   logic                    pvalid_ff, pvalid_in;
   logic [WORD_W-1:0]       pvalue_ff, pvalue_in;
   logic [WORD_W-1:0]       quo_ff, quo_in;
   logic [WORD_W-1:0]       rem_ff, rem_in;
   logic [WORD_W-1:0]       dvs_ff, dvs_in;
   logic                    neg_ff, neg_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]   rsp_user_ff, rsp_user_in;

   logic                    ram_wr_en;
   logic [ADDR_W-1:0]       ram_wr_addr;
   logic [WORD_W-1:0]       ram_wr_data;
   logic                    ram_rd_en;
   logic [ADDR_W-1:0]       ram_rd_addr;
   logic [WORD_W-1:0]       ram_rd_data;

   logic                    full;
   logic                    has_two;
   logic                    empty;
   logic                    is_arith;
   logic                    need_fetch;
   logic                    out_free;
   logic [CNT_W-1:0]        second_idx;
   logic [WORD_W-1:0]       product;
   logic [WORD_W:0]         shifted;
   logic [WORD_W:0]         diff;
   logic                    quo_bit;

   // Stack storage
   sme_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Stack bounds and decode
   assign full        = (depth_ff == FULL_CNT);
   assign has_two     = (depth_ff >= CNT_W'(2));
   assign empty       = (depth_ff == '0);
   assign is_arith    = op_ff inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV};
   assign need_fetch  = !stopped_ff && is_arith && has_two && !full &&
                        !((op_ff == OP_DIV) && (top_ff == '0));
   assign second_idx  = depth_ff - CNT_W'(2);
   assign ram_wr_addr = depth_ff[ADDR_W-1:0];
   assign ram_rd_addr = second_idx[ADDR_W-1:0];
   assign out_free    = !rsp_valid_ff || rsp_tready;

   // Multiplier (low word) and one divider step
   assign product = second_ff * top_ff;
   assign shifted = {rem_ff, quo_ff[WORD_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign quo_bit = !diff[WORD_W];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DECODE;
         end
         S_DECODE: begin
            state_in = need_fetch ? S_FETCH : S_DONE;
         end
         S_FETCH: begin
            state_in = (op_ff == OP_DIV) ? S_DIV : S_CALC;
         end
         S_CALC: begin
            state_in = S_WRITE;
         end
         S_DIV: begin
            if (step_ff == '0) state_in = S_SIGN;
         end
         S_SIGN: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath and outputs per state
   always_comb begin
      op_in        = op_ff;
      operand_in   = operand_ff;
      depth_in     = depth_ff;
      stopped_in   = stopped_ff;
      top_in       = top_ff;
      second_in    = second_ff;
      res_in       = res_ff;
      status_in    = status_ff;
      pvalid_in    = pvalid_ff;
      pvalue_in    = pvalue_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      req_tready   = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_data  = operand_ff;
      ram_rd_en    = 1'b0;

      case (state_ff)
         // Take a word and clear the per-item result
         S_IDLE: begin
            req_tready = !reset;
            if (req_tvalid) begin
               op_in      = opcode_type'(req_tuser);
               operand_in = req_tdata;
               status_in  = ST_OK;
               pvalid_in  = 1'b0;
               pvalue_in  = '0;
            end
         end
         // Check bounds, finish simple opcodes, start the second-entry read
         S_DECODE: begin
            if (stopped_ff) begin
               status_in = ST_HALTED;
            end else begin
               case (op_ff)
                  OP_PUSH: begin
                     if (full) begin
                        status_in = ST_OVERFLOW;
                     end else begin
                        ram_wr_en = 1'b1;
                        top_in    = operand_ff;
                        depth_in  = depth_ff + CNT_W'(1);
                     end
                  end
                  OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                     if (!has_two) begin
                        status_in = ST_UNDERFLOW;
                     end else if (full) begin
                        status_in = ST_OVERFLOW;
                     end else if ((op_ff == OP_DIV) && (top_ff == '0)) begin
                        status_in = ST_DIVZERO;
                     end else begin
                        ram_rd_en = 1'b1;
                     end
                  end
                  OP_PRINT: begin
                     if (empty) begin
                        status_in = ST_UNDERFLOW;
                     end else begin
                        pvalid_in = 1'b1;
                        pvalue_in = top_ff;
                     end
                  end
                  OP_HALT: begin
                     stopped_in = 1'b1;
                  end
                  default: begin
                     stopped_in = 1'b1;
                     status_in  = ST_UNKNOWN;
                  end
               endcase
            end
         end
         // Capture the second entry and load the divider magnitudes
         S_FETCH: begin
            second_in = ram_rd_data;
            neg_in    = ram_rd_data[WORD_W-1] ^ top_ff[WORD_W-1];
            quo_in    = ram_rd_data[WORD_W-1] ? -ram_rd_data : ram_rd_data;
            dvs_in    = top_ff[WORD_W-1] ? -top_ff : top_ff;
            rem_in    = '0;
            step_in   = STEP_W'(WORD_W - 1);
         end
         // Add, subtract or multiply (low word)
         S_CALC: begin
            case (op_ff)
               OP_ADD:  res_in = second_ff + top_ff;
               OP_SUB:  res_in = second_ff - top_ff;
               default: res_in = product;
            endcase
         end
         // One restoring quotient bit per cycle
         S_DIV: begin
            rem_in  = quo_bit ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
            quo_in  = {quo_ff[WORD_W-2:0], quo_bit};
            step_in = step_ff - STEP_W'(1);
         end
         // Apply the quotient sign, truncating toward zero
         S_SIGN: begin
            res_in = neg_ff ? -quo_ff : quo_ff;
         end
         // Push the result
         S_WRITE: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = res_ff;
            top_in      = res_ff;
            depth_in    = depth_ff + CNT_W'(1);
         end
         // Hand the result to the output register once it is free
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{RSP_PAD_W{1'b0}}, stopped_ff,
                               DEPTH_OUT_W'(depth_ff), pvalue_ff};
               rsp_user_in  = {pvalid_ff, status_ff};
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      operand_ff  <= operand_in;
      top_ff      <= top_in;
      second_ff   <= second_in;
      res_ff      <= res_in;
      status_ff   <= status_in;
      pvalid_ff   <= pvalid_in;
      pvalue_ff   <= pvalue_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      neg_ff      <= neg_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Depth stays within the stack
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= FULL_CNT)
      else $error("stack depth beyond capacity");

   // Depth only grows, one entry at a time
   a_depth_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (depth_ff != $past(depth_ff)) |->
         depth_ff == $past(depth_ff) + CNT_W'(1))
      else $error("stack depth changed by other than one");

   // Halted flag sticks until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("halted flag cleared without reset");

   // A second-entry read is followed by its capture
   a_fetch_follows: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |=> state_ff == S_FETCH)
      else $error("stack read not followed by fetch");

   // No stack write while halted
   a_no_write_halted: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> !stopped_ff)
      else $error("stack written while halted");

endmodule

### rtl/sme_ram.sv
// ============================================================================
// sme_ram
// Generic single-clock RAM: one write port, one read port with registered
// read data.
// ============================================================================
module sme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
